@@ hdl/pmsd_pkg.sv @@
// Package for the partition max-sum block: sizes, the sequencer state type,
// the scan control struct and the window limit clamp.
// No dependencies; every other file imports it.
package pmsd_pkg;

   // Longest segment the block can score; the history depth
   localparam int MAX_K    = 16;
   localparam int DATA_W   = 16;
   localparam int SUM_W    = 40;
   localparam int WL_W     = 5;
   localparam int CNT_W    = $clog2(MAX_K + 1);
   localparam int IDX_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int PROD_W   = DATA_W + CNT_W;
   localparam int CMP_W    = (CNT_W > WL_W) ? CNT_W : WL_W;

   localparam logic [WL_W-1:0] WL_RESET = WL_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } ctrl_state_type;

   // One scan step handed from the sequencer to the shared unit
   typedef struct packed {
      logic             clear;     // new transaction: reset running max and best
      logic             issue;     // a segment length enters the unit
      logic [CNT_W-1:0] seg_len;   // segment length of this step
      logic             sum_zero;  // prefix before the segment is empty
   } scan_ctrl_type;

   // Clamp the configured window to 1..MAX_K and to the elements seen
   function automatic logic [CNT_W-1:0] clamp_limit(input logic [WL_W-1:0] wl,
                                                    input logic [CNT_W-1:0] cnt);
      logic [CMP_W-1:0] w;
      logic [CMP_W-1:0] c;
      w = CMP_W'(wl);
      c = CMP_W'(cnt);
      if (w == '0) begin
         w = CMP_W'(1);
      end
      if (w > CMP_W'(MAX_K)) begin
         w = CMP_W'(MAX_K);
      end
      if (w > c) begin
         w = c;
      end
      return CNT_W'(w);
   endfunction

endpackage

@@ hdl/pmsd_if.sv @@
// Channel interfaces of the partition max-sum block: element input,
// result output and window limit write port. Uses pmsd_pkg for widths.
interface pmsd_req_if import pmsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] value;
   logic              start_req;

   modport source (output valid, output value, output start_req, input ready);
   modport sink   (input valid, input value, input start_req, output ready);
endinterface

interface pmsd_rsp_if import pmsd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] best_sum;

   modport source (output valid, output best_sum, input ready);
   modport sink   (input valid, input best_sum, output ready);
endinterface

interface pmsd_csr_if import pmsd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [WL_W-1:0] window_limit;

   modport source (output valid, output window_limit, input ready);
   modport sink   (input valid, input window_limit, output ready);
endinterface

@@ hdl/pmsd_history.sv @@
// Value and best-sum history lines of the partition max-sum block, newest
// first, with one selected read port each. Uses pmsd_pkg.
module pmsd_history import pmsd_pkg::*; (
   input  logic              clock,
   input  logic              push_value,
   input  logic [DATA_W-1:0] value_in,
   input  logic              push_sum,
   input  logic [SUM_W-1:0]  sum_in,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [DATA_W-1:0] value_rd,
   output logic [SUM_W-1:0]  sum_rd
);

   logic [DATA_W-1:0] value_hist_ff [MAX_K];
   logic [SUM_W-1:0]  sum_hist_ff   [MAX_K];

   // Shift a new value in at the head, drop the oldest
   always_ff @(posedge clock) begin
      if (push_value) begin
         value_hist_ff[0] <= value_in;
         for (int k = 1; k < MAX_K; k++) begin
            value_hist_ff[k] <= value_hist_ff[k-1];
         end
      end
   end

   // Shift a new best prefix sum in at the head
   always_ff @(posedge clock) begin
      if (push_sum) begin
         sum_hist_ff[0] <= sum_in;
         for (int k = 1; k < MAX_K; k++) begin
            sum_hist_ff[k] <= sum_hist_ff[k-1];
         end
      end
   end

   assign value_rd = value_hist_ff[rd_idx];
   assign sum_rd   = sum_hist_ff[rd_idx];

endmodule

@@ hdl/pmsd_scan_unit.sv @@
// Shared scoring unit: running maximum, segment product, saturating add and
// best-so-far compare, one segment length per cycle. Uses pmsd_pkg.
module pmsd_scan_unit import pmsd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctrl_type     scan,
   input  logic [DATA_W-1:0] value_rd,
   input  logic [SUM_W-1:0]  sum_rd,
   output logic [SUM_W-1:0]  best
);

   logic              a_valid_ff, a_valid_in;
   logic [DATA_W-1:0] run_max_ff, run_max_in;
   logic [SUM_W-1:0]  sum_a_ff, sum_a_in;
   logic [CNT_W-1:0]  mult_j_ff, mult_j_in;
   logic [SUM_W-1:0]  best_ff, best_in;
   logic [PROD_W-1:0] prod;
   logic [SUM_W:0]    raw_sum;
   logic [SUM_W-1:0]  cand;

   // First step: fold the new value into the running max, pick the prefix sum
   always_comb begin
      a_valid_in = scan.issue;
      run_max_in = run_max_ff;
      sum_a_in   = sum_a_ff;
      mult_j_in  = mult_j_ff;
      if (scan.clear) begin
         a_valid_in = 1'b0;
         run_max_in = '0;
      end else if (scan.issue) begin
         run_max_in = (value_rd > run_max_ff) ? value_rd : run_max_ff;
         sum_a_in   = scan.sum_zero ? '0 : sum_rd;
         mult_j_in  = scan.seg_len;
      end
   end

   // Second step: score the segment, saturate, keep the best
   always_comb begin
      prod    = PROD_W'(run_max_ff) * PROD_W'(mult_j_ff);
      raw_sum = {1'b0, sum_a_ff} + (SUM_W + 1)'(prod);
      cand    = raw_sum[SUM_W] ? '1 : raw_sum[SUM_W-1:0];
      best_in = best_ff;
      if (scan.clear) begin
         best_in = '0;
      end else if (a_valid_ff && (cand > best_ff)) begin
         best_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_max_ff <= run_max_in;
      sum_a_ff   <= sum_a_in;
      mult_j_ff  <= mult_j_in;
      best_ff    <= best_in;
   end

   assign best = best_ff;

endmodule

@@ hdl/pmsd_ctrl.sv @@
// Sequencer of the partition max-sum block: takes a transaction, steps the
// segment length through the scan unit, then hands the result on. Uses pmsd_pkg.
module pmsd_ctrl import pmsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_start,
   input  logic [WL_W-1:0]  window_limit,
   input  logic             rsp_free,
   output logic             req_ready,
   output logic             push_value,
   output logic             push_sum,
   output logic [IDX_W-1:0] rd_idx,
   output scan_ctrl_type    scan
);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] prev_cnt_ff, prev_cnt_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] prev_cnt;
   logic [CNT_W-1:0] new_cnt;
   logic             accept;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   // A start flag drops the element count of the previous array
   assign prev_cnt = req_start ? '0 : count_ff;
   assign new_cnt  = (prev_cnt < CNT_W'(MAX_K)) ? prev_cnt + CNT_W'(1) : CNT_W'(MAX_K);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (j_ff == lim_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      push_value    = 1'b0;
      push_sum      = 1'b0;
      scan.clear    = 1'b0;
      scan.issue    = 1'b0;
      scan.seg_len  = j_ff;
      scan.sum_zero = (j_ff > prev_cnt_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            push_value = req_valid;
            scan.clear = req_valid;
         end
         ST_SCAN: begin
            scan.issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            push_sum = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign rd_idx = IDX_W'(j_ff - CNT_W'(1));

   // Counters: element count, scan limit and segment length
   always_comb begin
      count_in    = count_ff;
      prev_cnt_in = prev_cnt_ff;
      lim_in      = lim_ff;
      j_in        = j_ff;
      if (accept) begin
         count_in    = new_cnt;
         prev_cnt_in = prev_cnt;
         lim_in      = clamp_limit(window_limit, new_cnt);
         j_in        = CNT_W'(1);
      end else if (state_ff == ST_SCAN) begin
         j_in = j_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         prev_cnt_ff <= '0;
         lim_ff      <= CNT_W'(1);
         j_ff        <= CNT_W'(1);
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         prev_cnt_ff <= prev_cnt_in;
         lim_ff      <= lim_in;
         j_ff        <= j_in;
      end
   end

endmodule

@@ hdl/partition_max_sum_dp.sv @@
// Partition max-sum block, top level: window limit register, result
// register and the sequencer, history and scan unit. Uses pmsd_pkg, pmsd_if.
//
// Usage:
//   req_chan carries one array element (value) and start_req, which marks the
//   first element of a new array. rsp_chan returns, per element, best_sum: the
//   best partition score of the array prefix up to that element, saturating
//   at 2^40-1. The value for the last element is the answer for the array.
//   csr_chan (always ready) writes window_limit: largest segment length, 0 acts
//   as 1, above MAX_K as MAX_K. The user writes it while idle, unenforced.
// Sequence:
//   With L = min(window_limit, elements seen, MAX_K), the scan unit scores
//   segment lengths 1 to L, one segment length per cycle over two register
//   steps; the sequencer then drains the unit and, once rsp_chan is free,
//   stores the result. A new element is taken only after that, back in idle.
// Reset and stall:
//   Reset empties the result register, sets window_limit to 1 and returns the
//   sequencer to idle. The next element is accepted while a result still
//   waits on rsp_chan; its own result then waits until rsp_chan is taken.
module partition_max_sum_dp import pmsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pmsd_req_if.sink    req_chan,
   pmsd_rsp_if.source  rsp_chan,
   pmsd_csr_if.sink    csr_chan
);

   logic [WL_W-1:0]   window_limit_ff, window_limit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_free;
   logic              push_value;
   logic              push_sum;
   logic [IDX_W-1:0]  rd_idx;
   logic [DATA_W-1:0] value_rd;
   logic [SUM_W-1:0]  sum_rd;
   logic [SUM_W-1:0]  best;
   scan_ctrl_type     scan;

   // Window limit register
   assign csr_chan.ready = 1'b1;
   assign window_limit_in = csr_chan.valid ? csr_chan.window_limit : window_limit_ff;

   // Result register: load when empty or being drained
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push_sum) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = best;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_limit_ff <= WL_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_limit_ff <= window_limit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.best_sum = rsp_data_ff;

   pmsd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_start    (req_chan.start_req),
      .window_limit (window_limit_ff),
      .rsp_free     (rsp_free),
      .req_ready    (req_chan.ready),
      .push_value   (push_value),
      .push_sum     (push_sum),
      .rd_idx       (rd_idx),
      .scan         (scan)
   );

   pmsd_history u_history (
      .clock      (clock),
      .push_value (push_value),
      .value_in   (req_chan.value),
      .push_sum   (push_sum),
      .sum_in     (best),
      .rd_idx     (rd_idx),
      .value_rd   (value_rd),
      .sum_rd     (sum_rd)
   );

   pmsd_scan_unit u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan     (scan),
      .value_rd (value_rd),
      .sum_rd   (sum_rd),
      .best     (best)
   );

endmodule
